### rtl/gfm_pkg.sv
// Shared types, constants and neighbour tables for the grid frontier marker.
// No dependencies; the controller, datapath and top level use this package.
`timescale 1ns / 1ps

package gfm_pkg;

    // Grid capacity (cells along x and y)
    localparam int MAX_X_CELLS = 256;
    localparam int MAX_Y_CELLS = 256;

    // Address bits per axis; memory is row-major with a power-of-two stride
    localparam int X_AW = (MAX_X_CELLS > 1) ? $clog2(MAX_X_CELLS) : 1;
    localparam int Y_AW = (MAX_Y_CELLS > 1) ? $clog2(MAX_Y_CELLS) : 1;
    localparam int ADDR_W = X_AW + Y_AW;

    // Field widths
    localparam int COORD_W  = 8;
    localparam int SIZE_W   = 9;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;
    localparam int NB_W     = 3;
    localparam int CFG_IDX_W = 1;

    // Compare width: holds a size register, an effective size and a stepped
    // coordinate, with headroom so that zero minus one wraps out of range
    localparam int XS_W = $clog2(MAX_X_CELLS + 1);
    localparam int YS_W = $clog2(MAX_Y_CELLS + 1);
    localparam int XC_W = (XS_W > SIZE_W) ? XS_W : SIZE_W;
    localparam int YC_W = (YS_W > SIZE_W) ? YS_W : SIZE_W;

    // Operation codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_X_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y_SIZE = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    typedef enum logic [STATUS_W-1:0] {
        CELL_UNKNOWN  = 2'd0,
        CELL_FREE     = 2'd1,
        CELL_FRONTIER = 2'd2,
        CELL_OCCUPIED = 2'd3
    } cell_state_t;

    typedef enum logic [1:0] {
        OFS_ZERO,
        OFS_MINUS,
        OFS_PLUS
    } ofs_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TGT_RD,
        ST_TGT_CHK,
        ST_NB_RUN,
        ST_NB_DRAIN,
        ST_TGT_WR,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic clear_step;
        logic tgt_rd;
        logic capture_old;
        logic nb_issue;
        logic nb_check;
        logic k_inc;
        logic tgt_wr;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic tgt_in_grid;
        logic k_last;
        logic op_write;
        logic ns_free;
    } ctrl_status_t;

    // Neighbour offsets along x, in visiting order
    function automatic ofs_t nb_dx(input logic [NB_W-1:0] k);
        ofs_t o;
        case (k)
            3'd0: o = OFS_MINUS;
            3'd1: o = OFS_MINUS;
            3'd2: o = OFS_MINUS;
            3'd3: o = OFS_ZERO;
            3'd4: o = OFS_ZERO;
            3'd5: o = OFS_PLUS;
            3'd6: o = OFS_PLUS;
            3'd7: o = OFS_PLUS;
            default: o = OFS_ZERO;
        endcase
        return o;
    endfunction

    // Neighbour offsets along y, in visiting order
    function automatic ofs_t nb_dy(input logic [NB_W-1:0] k);
        ofs_t o;
        case (k)
            3'd0: o = OFS_ZERO;
            3'd1: o = OFS_MINUS;
            3'd2: o = OFS_PLUS;
            3'd3: o = OFS_MINUS;
            3'd4: o = OFS_PLUS;
            3'd5: o = OFS_ZERO;
            3'd6: o = OFS_MINUS;
            3'd7: o = OFS_PLUS;
            default: o = OFS_ZERO;
        endcase
        return o;
    endfunction

endpackage

### rtl/gfm_ctrl.sv
// Sequencing state machine for the grid frontier marker.
// Depends on gfm_pkg for the state, command and status types.
`timescale 1ns / 1ps

module gfm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  gfm_pkg::ctrl_status_t status,
    output gfm_pkg::ctrl_cmd_t    cmd
);

    gfm_pkg::state_t state_reg;
    gfm_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gfm_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;

        case (state_reg)
            gfm_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clr_last)
                    state_next = gfm_pkg::ST_IDLE;
            end
            gfm_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = gfm_pkg::ST_TGT_RD;
                end
            end
            gfm_pkg::ST_TGT_RD:
            begin
                // out-of-range target goes straight to the result
                if (status.tgt_in_grid)
                begin
                    cmd.tgt_rd = 1'b1;
                    state_next = gfm_pkg::ST_TGT_CHK;
                end
                else
                    state_next = gfm_pkg::ST_RESULT;
            end
            gfm_pkg::ST_TGT_CHK:
            begin
                cmd.capture_old = 1'b1;
                if (status.op_write && status.ns_free)
                    state_next = gfm_pkg::ST_NB_RUN;
                else if (status.op_write)
                    state_next = gfm_pkg::ST_TGT_WR;
                else
                    state_next = gfm_pkg::ST_RESULT;
            end
            gfm_pkg::ST_NB_RUN:
            begin
                // read neighbour k while checking neighbour k-1
                cmd.nb_issue = 1'b1;
                cmd.nb_check = 1'b1;
                cmd.k_inc    = 1'b1;
                if (status.k_last)
                    state_next = gfm_pkg::ST_NB_DRAIN;
            end
            gfm_pkg::ST_NB_DRAIN:
            begin
                cmd.nb_check = 1'b1;
                state_next   = gfm_pkg::ST_TGT_WR;
            end
            gfm_pkg::ST_TGT_WR:
            begin
                cmd.tgt_wr = 1'b1;
                state_next = gfm_pkg::ST_RESULT;
            end
            gfm_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = gfm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gfm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/gfm_datapath.sv
// Datapath for the grid frontier marker: size registers, item registers,
// neighbour stepping, the cell memory and the result register. Uses gfm_pkg.
`timescale 1ns / 1ps

module gfm_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  gfm_pkg::ctrl_cmd_t               cmd,
    output gfm_pkg::ctrl_status_t            status,
    input  logic                             cfg_wr,
    input  logic [gfm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gfm_pkg::SIZE_W-1:0]       cfg_data,
    input  logic                             operation,
    input  logic [gfm_pkg::COORD_W-1:0]      cell_x,
    input  logic [gfm_pkg::COORD_W-1:0]      cell_y,
    input  logic [gfm_pkg::STATUS_W-1:0]     new_status,
    output logic [gfm_pkg::STATUS_W-1:0]     old_status,
    output logic [gfm_pkg::COUNT_W-1:0]      marked_count,
    output logic                             range_error
);

    localparam int XCW = gfm_pkg::XC_W;
    localparam int YCW = gfm_pkg::YC_W;
    localparam int AW  = gfm_pkg::ADDR_W;
    localparam int XAW = gfm_pkg::X_AW;
    localparam int YAW = gfm_pkg::Y_AW;
    localparam int SW  = gfm_pkg::STATUS_W;
    localparam int CNW = gfm_pkg::COUNT_W;
    localparam int KW  = gfm_pkg::NB_W;
    localparam int DEPTH = 1 << AW;

    // Configuration
    logic [gfm_pkg::SIZE_W-1:0] grid_x_size_reg;
    logic [gfm_pkg::SIZE_W-1:0] grid_y_size_reg;

    // Item and progress registers
    logic                        op_reg;
    logic [gfm_pkg::COORD_W-1:0] x_reg;
    logic [gfm_pkg::COORD_W-1:0] y_reg;
    logic [SW-1:0]               ns_reg;
    logic [KW-1:0]               k_reg;
    logic [SW-1:0]               old_reg;
    logic [CNW-1:0]              count_reg;
    logic [AW-1:0]               clr_addr_reg;
    logic                        pend_valid_reg;
    logic [AW-1:0]               pend_addr_reg;

    // Result register
    logic [SW-1:0]  old_status_reg;
    logic [CNW-1:0] marked_count_reg;
    logic           range_error_reg;

    // Cell memory
    logic [SW-1:0] mem [DEPTH];
    logic [SW-1:0] rdata_reg;

    logic [XCW-1:0] xs_eff;
    logic [YCW-1:0] ys_eff;
    logic [XCW-1:0] tx;
    logic [YCW-1:0] ty;
    logic [XCW-1:0] nx;
    logic [YCW-1:0] ny;
    logic           tgt_in_grid;
    logic           nb_in_grid;
    logic [AW-1:0]  tgt_addr;
    logic [AW-1:0]  nb_addr;
    logic           mark_hit;
    logic           rd_en;
    logic [AW-1:0]  raddr;
    logic           we;
    logic [AW-1:0]  waddr;
    logic [SW-1:0]  wdata;

    // Step a coordinate by one; zero minus one wraps to all ones, which is
    // never below an effective size
    function automatic logic [XCW-1:0] step_x(input logic [XCW-1:0] c,
                                              input gfm_pkg::ofs_t o);
        logic [XCW-1:0] r;
        case (o)
            gfm_pkg::OFS_MINUS: r = c - XCW'(1);
            gfm_pkg::OFS_PLUS:  r = c + XCW'(1);
            default:            r = c;
        endcase
        return r;
    endfunction

    function automatic logic [YCW-1:0] step_y(input logic [YCW-1:0] c,
                                              input gfm_pkg::ofs_t o);
        logic [YCW-1:0] r;
        case (o)
            gfm_pkg::OFS_MINUS: r = c - YCW'(1);
            gfm_pkg::OFS_PLUS:  r = c + YCW'(1);
            default:            r = c;
        endcase
        return r;
    endfunction

    // Saturate size registers at the grid capacity
    always_comb
    begin
        if (XCW'(grid_x_size_reg) > XCW'(gfm_pkg::MAX_X_CELLS))
            xs_eff = XCW'(gfm_pkg::MAX_X_CELLS);
        else
            xs_eff = XCW'(grid_x_size_reg);
        if (YCW'(grid_y_size_reg) > YCW'(gfm_pkg::MAX_Y_CELLS))
            ys_eff = YCW'(gfm_pkg::MAX_Y_CELLS);
        else
            ys_eff = YCW'(grid_y_size_reg);
    end

    always_comb
    begin
        tx          = XCW'(x_reg);
        ty          = YCW'(y_reg);
        nx          = step_x(tx, gfm_pkg::nb_dx(k_reg));
        ny          = step_y(ty, gfm_pkg::nb_dy(k_reg));
        tgt_in_grid = (tx < xs_eff) && (ty < ys_eff);
        nb_in_grid  = (nx < xs_eff) && (ny < ys_eff);
        tgt_addr    = {ty[YAW-1:0], tx[XAW-1:0]};
        nb_addr     = {ny[YAW-1:0], nx[XAW-1:0]};
        mark_hit    = cmd.nb_check && pend_valid_reg
                      && (rdata_reg == gfm_pkg::CELL_UNKNOWN);
    end

    // Memory port selection
    always_comb
    begin
        rd_en = cmd.tgt_rd || (cmd.nb_issue && nb_in_grid);
        raddr = cmd.tgt_rd ? tgt_addr : nb_addr;

        we    = 1'b0;
        waddr = tgt_addr;
        wdata = ns_reg;
        if (cmd.clear_step)
        begin
            we    = 1'b1;
            waddr = clr_addr_reg;
            wdata = gfm_pkg::CELL_UNKNOWN;
        end
        else if (mark_hit)
        begin
            we    = 1'b1;
            waddr = pend_addr_reg;
            wdata = gfm_pkg::CELL_FRONTIER;
        end
        else if (cmd.tgt_wr)
        begin
            we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (rd_en)
            rdata_reg <= mem[raddr];
    end

    // Size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_x_size_reg <= gfm_pkg::SIZE_RESET;
            grid_y_size_reg <= gfm_pkg::SIZE_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                gfm_pkg::CFG_GRID_X_SIZE: grid_x_size_reg <= cfg_data;
                gfm_pkg::CFG_GRID_Y_SIZE: grid_y_size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Control-side progress state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg   <= '0;
            k_reg          <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
                clr_addr_reg <= clr_addr_reg + AW'(1);
            if (cmd.load_in)
                k_reg <= '0;
            else if (cmd.k_inc)
                k_reg <= k_reg + KW'(1);
            pend_valid_reg <= cmd.nb_issue && nb_in_grid;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg    <= operation;
            x_reg     <= cell_x;
            y_reg     <= cell_y;
            ns_reg    <= new_status;
            count_reg <= '0;
        end
        else if (mark_hit)
            count_reg <= count_reg + CNW'(1);
        if (cmd.nb_issue)
            pend_addr_reg <= nb_addr;
        if (cmd.capture_old)
            old_reg <= rdata_reg;
        if (cmd.load_out)
        begin
            range_error_reg  <= !tgt_in_grid;
            old_status_reg   <= tgt_in_grid ? old_reg : SW'(gfm_pkg::CELL_UNKNOWN);
            marked_count_reg <= tgt_in_grid ? count_reg : '0;
        end
    end

    always_comb
    begin
        status.clr_last    = &clr_addr_reg;
        status.tgt_in_grid = tgt_in_grid;
        status.k_last      = &k_reg;
        status.op_write    = (op_reg == gfm_pkg::OP_WRITE);
        status.ns_free     = (ns_reg == gfm_pkg::CELL_FREE);
    end

    assign old_status   = old_status_reg;
    assign marked_count = marked_count_reg;
    assign range_error  = range_error_reg;

endmodule

### rtl/grid_frontier_marker.sv
// Top level of the grid frontier marker: occupancy grid with frontier marking.
// Depends on gfm_pkg, gfm_ctrl and gfm_datapath.
`timescale 1ns / 1ps

//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | operation, cell_x, cell_y, new_status
//  out     | out_valid / out_stall| old_status, marked_count, range_error
//  cfg     | cfg_valid / cfg_ready| cfg_index (0 grid_x_size, 1 grid_y_size),
//          |                      | cfg_data
//
//  Steps per item: a read reads the target and returns its old state; a write
//  of a non-free state also writes the target; an out-of-range target goes
//  straight to the result; a write of free reads the eight neighbours through
//  the single read port of the grid memory, one per cycle, with the frontier
//  write of the previous neighbour overlapped on the write port, then writes the target.
//  After reset the grid memory is swept to unknown, one cell a cycle, over
//  every cell; input is stalled meanwhile, configuration writes are taken at
//  all times.
//  A finished result waits in an output register while the next item is
//  taken and worked on; that item's result is held back, and input stalled,
//  until the register has emptied or is emptying.

module grid_frontier_marker (
    input  logic                               clk,
    input  logic                               rst_n,
    // input items
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               operation,
    input  logic [gfm_pkg::COORD_W-1:0]        cell_x,
    input  logic [gfm_pkg::COORD_W-1:0]        cell_y,
    input  logic [gfm_pkg::STATUS_W-1:0]       new_status,
    // result items
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [gfm_pkg::STATUS_W-1:0]       old_status,
    output logic [gfm_pkg::COUNT_W-1:0]        marked_count,
    output logic                               range_error,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gfm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gfm_pkg::SIZE_W-1:0]         cfg_data
);

    gfm_pkg::ctrl_cmd_t    cmd;
    gfm_pkg::ctrl_status_t status;
    logic                  cfg_wr;

    // Size registers live in the datapath and take a write in any cycle
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Sequencer: clear sweep, target read, neighbour pass, target write, result
    gfm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Grid memory, coordinate stepping, range checks and result register
    gfm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr       (cfg_wr),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .operation    (operation),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .new_status   (new_status),
        .old_status   (old_status),
        .marked_count (marked_count),
        .range_error  (range_error)
    );

endmodule

### dv/grid_frontier_marker_tb.sv
// Self-checking testbench for grid_frontier_marker: a directed stimulus table, then
// random items over several grid sizes, checked against an in-bench grid predictor.
// Depends on gfm_pkg and the grid_frontier_marker RTL; reads no files.
`timescale 1ns / 1ps

module grid_frontier_marker_tb;

    import gfm_pkg::*;

    // Result of one item, as the block should return it
    typedef struct packed {
        cell_state_t          old;
        logic [COUNT_W-1:0]   count;
        logic                 err;
    } grid_result_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    // One line of the directed table: either a size register write or an item.
    // Rows with has_want carry a hand-typed result; the rest use the predictor.
    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [SIZE_W-1:0]       reg_val;
        logic                    op;
        logic [COORD_W-1:0]      x;
        logic [COORD_W-1:0]      y;
        cell_state_t             ns;
        logic                    has_want;
        grid_result_t            want;
    } stim_row_t;

    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int SETTLE_CYCLES   = 20;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int LONG_HOLD       = 600;
    localparam int HOLD_AT_RESULT  = 120;

    // Grid sizes for the random phases: extremes, a single row or column, saturating
    // values above capacity, a zero size and a couple of small odd shapes
    int phase_w [RANDOM_PHASES] = '{8, 256, 1, 256, 3, 16, 0, 300, 511, 12};
    int phase_h [RANDOM_PHASES] = '{8, 256, 256, 1, 5, 16, 200, 2, 511, 9};

    // Block ports; every input starts at a known value
    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic                  operation    = OP_READ;
    logic [COORD_W-1:0]    cell_x       = '0;
    logic [COORD_W-1:0]    cell_y       = '0;
    logic [STATUS_W-1:0]   new_status   = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [STATUS_W-1:0]   old_status;
    logic [COUNT_W-1:0]    marked_count;
    logic                  range_error;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_GRID_X_SIZE;
    logic [SIZE_W-1:0]     cfg_data     = '0;

    // Predictor state: its own copy of the grid and the two size registers
    cell_state_t           grid_cells [MAX_X_CELLS*MAX_Y_CELLS];
    logic [SIZE_W-1:0]     grid_w_reg;
    logic [SIZE_W-1:0]     grid_h_reg;

    grid_result_t          pending_results [$];
    stim_row_t             directed_rows [$];
    int                    items_sent;
    int                    error_count;

    grid_frontier_marker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .new_status   (new_status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .old_status   (old_status),
        .marked_count (marked_count),
        .range_error  (range_error),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: the reset sweep plus about 725 items at their slowest (sender gap,
    // free-write walk and receiver stall back to back) comes to roughly 1.1 ms; allow
    // several times that
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        error_count++;
    endtask

    // A size register above capacity saturates; zero leaves no cell in range
    function automatic int eff_extent(input logic [SIZE_W-1:0] v, input int cap);
        return (int'(v) > cap) ? cap : int'(v);
    endfunction

    // Apply one item to the predicted grid and return what the block should answer.
    // A write of free turns every unknown in-range neighbour into frontier.
    function automatic grid_result_t predict_cell_update(input logic op,
                                                         input logic [COORD_W-1:0] x,
                                                         input logic [COORD_W-1:0] y,
                                                         input cell_state_t ns);
        grid_result_t r;
        int xe;
        int ye;
        int nx;
        int ny;
        int at;
        xe = eff_extent(grid_w_reg, MAX_X_CELLS);
        ye = eff_extent(grid_h_reg, MAX_Y_CELLS);
        r.old = CELL_UNKNOWN;
        r.count = '0;
        r.err = 1'b0;
        if (int'(x) >= xe || int'(y) >= ye)
        begin
            // out-of-range target: flag it and leave the grid alone
            r.err = 1'b1;
            return r;
        end
        // fixed row stride, so cells keep their place when the sizes change
        at = int'(y) * MAX_X_CELLS + int'(x);
        r.old = grid_cells[at];
        if (op == OP_WRITE)
        begin
            if (ns == CELL_FREE)
            begin
                for (int dy = -1; dy <= 1; dy++)
                begin
                    for (int dx = -1; dx <= 1; dx++)
                    begin
                        nx = int'(x) + dx;
                        ny = int'(y) + dy;
                        if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0 && nx < xe && ny < ye
                            && grid_cells[ny*MAX_X_CELLS + nx] == CELL_UNKNOWN)
                        begin
                            grid_cells[ny*MAX_X_CELLS + nx] = CELL_FRONTIER;
                            r.count++;
                        end
                    end
                end
            end
            grid_cells[at] = ns;
        end
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [SIZE_W-1:0] v);
        stim_row_t s;
        s = '0;
        s.kind = ROW_CFG;
        s.reg_idx = idx;
        s.reg_val = v;
        return s;
    endfunction

    function automatic stim_row_t op_row(input logic op, input int x, input int y,
                                         input cell_state_t ns);
        stim_row_t s;
        s = '0;
        s.kind = ROW_ITEM;
        s.op = op;
        s.x = x[COORD_W-1:0];
        s.y = y[COORD_W-1:0];
        s.ns = ns;
        return s;
    endfunction

    function automatic stim_row_t known_row(input logic op, input int x, input int y,
                                            input cell_state_t ns, input cell_state_t old,
                                            input int count, input logic err);
        stim_row_t s;
        s = op_row(op, x, y, ns);
        s.has_want = 1'b1;
        s.want.old = old;
        s.want.count = count[COUNT_W-1:0];
        s.want.err = err;
        return s;
    endfunction

    // Offer one item, hold it until the block takes it, then log its expected result.
    // Entered and left on a rising edge; valid stays high for a back-to-back item.
    task automatic send_item(input logic op, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input cell_state_t ns,
                             input logic has_want, input grid_result_t want);
        grid_result_t r;
        int gap;
        // every fourth stretch of 50 items goes without gaps
        gap = ((items_sent / 50) % 4 == 3) ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        cell_x     <= x;
        cell_y     <= y;
        new_status <= ns;
        do @(posedge clk); while (in_stall);
        r = predict_cell_update(op, x, y, ns);
        pending_results.push_back(has_want ? want : r);
        items_sent++;
    endtask

    // Drop valid, wait for every outstanding result, then let the block settle
    task automatic drain_results;
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one size register; only called with nothing in flight.
    // After the write, valid is dropped and the task waits for the clock so that a following write starts clean.
    task automatic write_size_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [SIZE_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_GRID_X_SIZE)
            grid_w_reg = v;
        else
            grid_h_reg = v;
        @(posedge clk);
    endtask

    // Receiver: draw a stall per item, hold off once for a long stretch so that the
    // block backs up into its input, and check each result in order
    initial
    begin
        int hold;
        int got;
        grid_result_t want;
        got = 0;
        @(posedge clk);
        forever
        begin
            if (got == HOLD_AT_RESULT)
                hold = LONG_HOLD;
            else if ((got / 60) % 4 == 1)
                hold = 0;
            else
                hold = $urandom_range(0, 16);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            if (pending_results.size() == 0)
            begin
                flag_mismatch("result item arrived with nothing pending");
            end
            else
            begin
                want = pending_results.pop_front();
                if (old_status !== want.old)
                    flag_mismatch($sformatf("old_status %0d, want %0d", old_status, want.old));
                if (marked_count !== want.count)
                    flag_mismatch($sformatf("marked_count %0d, want %0d",
                                            marked_count, want.count));
                if (range_error !== want.err)
                    flag_mismatch($sformatf("range_error %0b, want %0b",
                                            range_error, want.err));
            end
            got++;
        end
    end

    // Main sequence: reset, directed table, random phases, drain and verdict
    initial
    begin
        int r;
        int xe;
        int ye;
        int base_x;
        int base_y;
        int cx;
        int cy;
        logic op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        cell_state_t ns;
        grid_result_t none;

        none = '0;
        items_sent = 0;
        error_count = 0;
        foreach (grid_cells[i])
            grid_cells[i] = CELL_UNKNOWN;
        grid_w_reg = SIZE_RESET;
        grid_h_reg = SIZE_RESET;

        // Directed table. Rows after reset, at corners and at range errors carry
        // their answer; the rest lean on the predictor.
        // Reset sizes, fresh grid: everything reads unknown
        directed_rows.push_back(known_row(OP_READ, 0, 0, CELL_UNKNOWN,
                                          CELL_UNKNOWN, 0, 1'b0));
        directed_rows.push_back(known_row(OP_READ, 255, 255, CELL_OCCUPIED,
                                          CELL_UNKNOWN, 0, 1'b0));
        // Corner free writes: three neighbours in range
        directed_rows.push_back(known_row(OP_WRITE, 0, 0, CELL_FREE,
                                          CELL_UNKNOWN, 3, 1'b0));
        directed_rows.push_back(known_row(OP_READ, 1, 1, CELL_UNKNOWN,
                                          CELL_FRONTIER, 0, 1'b0));
        directed_rows.push_back(known_row(OP_WRITE, 255, 255, CELL_FREE,
                                          CELL_UNKNOWN, 3, 1'b0));
        directed_rows.push_back(known_row(OP_WRITE, 255, 0, CELL_OCCUPIED,
                                          CELL_UNKNOWN, 0, 1'b0));
        directed_rows.push_back(op_row(OP_WRITE, 255, 0, CELL_FREE));
        // Interior: full ring, then a partly known ring beside it
        directed_rows.push_back(op_row(OP_WRITE, 128, 128, CELL_FREE));
        directed_rows.push_back(op_row(OP_WRITE, 129, 128, CELL_FREE));
        directed_rows.push_back(op_row(OP_READ, 130, 129, CELL_UNKNOWN));
        // Non-free writes leave the neighbours alone
        directed_rows.push_back(op_row(OP_WRITE, 128, 128, CELL_UNKNOWN));
        directed_rows.push_back(op_row(OP_WRITE, 128, 128, CELL_FRONTIER));
        directed_rows.push_back(op_row(OP_WRITE, 128, 128, CELL_FREE));
        directed_rows.push_back(op_row(OP_READ, 129, 128, CELL_OCCUPIED));
        directed_rows.push_back(op_row(OP_WRITE, 0, 255, CELL_FREE));
        directed_rows.push_back(op_row(OP_WRITE, 170, 85, CELL_FRONTIER));
        directed_rows.push_back(op_row(OP_WRITE, 85, 170, CELL_FREE));
        // Zero width: nothing is in range
        directed_rows.push_back(cfg_row(CFG_GRID_X_SIZE, 9'd0));
        directed_rows.push_back(known_row(OP_READ, 0, 0, CELL_UNKNOWN,
                                          CELL_UNKNOWN, 0, 1'b1));
        // Width above capacity saturates; zero height
        directed_rows.push_back(cfg_row(CFG_GRID_X_SIZE, 9'd511));
        directed_rows.push_back(cfg_row(CFG_GRID_Y_SIZE, 9'd0));
        directed_rows.push_back(known_row(OP_WRITE, 5, 5, CELL_FREE,
                                          CELL_UNKNOWN, 0, 1'b1));
        // Four rows: neighbours on row 4 are skipped, row 4 itself is an error
        directed_rows.push_back(cfg_row(CFG_GRID_Y_SIZE, 9'd4));
        directed_rows.push_back(op_row(OP_WRITE, 255, 3, CELL_FREE));
        directed_rows.push_back(known_row(OP_READ, 10, 4, CELL_UNKNOWN,
                                          CELL_UNKNOWN, 0, 1'b1));
        // Single cell grid: no neighbour at all
        directed_rows.push_back(cfg_row(CFG_GRID_X_SIZE, 9'd1));
        directed_rows.push_back(cfg_row(CFG_GRID_Y_SIZE, 9'd1));
        directed_rows.push_back(op_row(OP_WRITE, 0, 0, CELL_FREE));
        directed_rows.push_back(known_row(OP_WRITE, 1, 0, CELL_FREE,
                                          CELL_UNKNOWN, 0, 1'b1));
        // Grow back: cells hidden by the small grid keep their state
        directed_rows.push_back(cfg_row(CFG_GRID_X_SIZE, 9'd256));
        directed_rows.push_back(cfg_row(CFG_GRID_Y_SIZE, 9'd256));
        directed_rows.push_back(op_row(OP_READ, 1, 0, CELL_UNKNOWN));
        directed_rows.push_back(op_row(OP_READ, 254, 2, CELL_UNKNOWN));

        // Hold reset, then release it; the block sweeps its grid while stalling input
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                drain_results();
                write_size_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end
            else
            begin
                send_item(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
                          directed_rows[i].ns, directed_rows[i].has_want,
                          directed_rows[i].want);
            end
        end

        // Random phases: most items cluster in a small window so that free writes
        // meet frontier and free neighbours; the rest roam the grid or beyond it
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_results();
            write_size_reg(CFG_GRID_X_SIZE, phase_w[p][SIZE_W-1:0]);
            write_size_reg(CFG_GRID_Y_SIZE, phase_h[p][SIZE_W-1:0]);
            xe = eff_extent(grid_w_reg, MAX_X_CELLS);
            ye = eff_extent(grid_h_reg, MAX_Y_CELLS);
            base_x = 0;
            base_y = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // move the cluster now and then
                if (n % 12 == 0)
                begin
                    base_x = (xe > 0) ? $urandom_range(0, xe - 1) : 0;
                    base_y = (ye > 0) ? $urandom_range(0, ye - 1) : 0;
                end
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    cx = base_x + int'($urandom_range(0, 6)) - 3;
                    cy = base_y + int'($urandom_range(0, 6)) - 3;
                    cx = (cx < 0) ? 0 : (cx > 255) ? 255 : cx;
                    cy = (cy < 0) ? 0 : (cy > 255) ? 255 : cy;
                end
                else if (r < 85)
                begin
                    cx = (xe > 0) ? $urandom_range(0, xe - 1) : 0;
                    cy = (ye > 0) ? $urandom_range(0, ye - 1) : 0;
                end
                else
                begin
                    cx = $urandom_range(0, 255);
                    cy = $urandom_range(0, 255);
                end
                x = cx[COORD_W-1:0];
                y = cy[COORD_W-1:0];
                op = ($urandom_range(0, 99) < 65) ? OP_WRITE : OP_READ;
                ns = $urandom_range(0, 1) ? CELL_FREE : cell_state_t'($urandom_range(0, 3));
                send_item(op, x, y, ns, 1'b0, none);
            end
        end

        // Wait out the last results, then account for anything never returned
        drain_results();
        while (pending_results.size() != 0)
        begin
            void'(pending_results.pop_front());
            flag_mismatch("expected result item never arrived");
        end

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
